// ===== hdl/pinhole_ray_direction_gen_core_assert.svh =====
// Assertion macros for the pinhole ray direction generator.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef PINHOLE_RAY_DIRECTION_GEN_CORE_ASSERT_SVH
`define PINHOLE_RAY_DIRECTION_GEN_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PRDG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRDG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/prdg_pkg.sv =====
// Shared widths, register indexes and constants of the ray direction generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package prdg_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int COORD_W    = 12;
    localparam int SCALE_W    = 24;
    localparam int ROW_W      = 48;
    localparam int ENT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(MAX_DIM - 1);

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAN_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAN_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2 = 3'd6;

    localparam logic [SCALE_W-1:0] RST_SCALE_X = 24'd52429;
    localparam logic [SCALE_W-1:0] RST_SCALE_Y = 24'd69905;
    localparam logic [SCALE_W-1:0] RST_TAN     = 24'd65536;
    localparam logic [ROW_W-1:0]   RST_ROW0    = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0]   RST_ROW1    = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0]   RST_ROW2    = 48'h4000_0000_0000;

    localparam int PROD_W  = 37;
    localparam int CAM_W   = 39;
    localparam int TERM_W  = 55;
    localparam int DIR_W   = 57;
    localparam int NORM_W  = 30;
    localparam int SQ_W    = 60;
    localparam int LSQ_W   = 62;
    localparam int ROOT_W  = 31;
    localparam int NUM_W   = 46;
    localparam int QUOT_W  = 16;
    localparam int OUT_W   = 16;
    localparam int SHIFT_W = 6;
    localparam int FRAC_W  = 15;

    localparam int FRONT_LAT = 9;
    localparam int SQRT_LAT  = ROOT_W;
    localparam int DIV_LAT   = QUOT_W;
    localparam int PIPE_LAT  = FRONT_LAT + SQRT_LAT + DIV_LAT + 1;
    localparam int NEG_LAT   = 5 + SQRT_LAT + DIV_LAT;

    localparam logic [QUOT_W-1:0] Q_ONE     = 16'd32768;
    localparam logic [QUOT_W-1:0] Q_POS_MAX = 16'd32767;

endpackage

`default_nettype wire

// ===== hdl/prdg_sqrt_pipe.sv =====
// Pipelined floor square root, one root bit resolved per register stage.
// Depends on prdg_pkg for the radicand and root widths.
`timescale 1ns / 1ps
`default_nettype none

module prdg_sqrt_pipe
    import prdg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [LSQ_W-1:0]  rad,
    output logic      [ROOT_W-1:0] root
);

    logic [LSQ_W-1:0]  rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int I = ROOT_W - 1 - k;
        logic [LSQ_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [LSQ_W-1:0]  trial;

        if (k == 0) begin : g_first
            assign rem_in  = rad;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign trial = (LSQ_W'(root_in) << (I + 1)) | (LSQ_W'(1) << (2 * I));

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_in >= trial) begin
                    rem_reg[k]  <= rem_in - trial;
                    root_reg[k] <= root_in | (ROOT_W'(1) << I);
                end else begin
                    rem_reg[k]  <= rem_in;
                    root_reg[k] <= root_in;
                end
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ===== hdl/prdg_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on prdg_pkg; a zero divisor gives a zero quotient.
`timescale 1ns / 1ps
`default_nettype none

module prdg_div_pipe
    import prdg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [ROOT_W-1:0] den,
    output logic      [QUOT_W-1:0] quot
);

    logic [NUM_W-1:0]  rem_reg [0:QUOT_W-1];
    logic [QUOT_W-1:0] q_reg   [0:QUOT_W-1];
    logic [ROOT_W-1:0] den_reg [0:QUOT_W-1];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        localparam int I = QUOT_W - 1 - k;
        logic [NUM_W-1:0]  rem_in;
        logic [QUOT_W-1:0] q_in;
        logic [ROOT_W-1:0] den_in;
        logic [NUM_W:0]    sub_val;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign q_in   = '0;
            assign den_in = den;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        assign sub_val = (NUM_W + 1)'(den_in) << I;

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k] <= den_in;
                if ({1'b0, rem_in} >= sub_val) begin
                    rem_reg[k] <= NUM_W'({1'b0, rem_in} - sub_val);
                    q_reg[k]   <= q_in | (QUOT_W'(1) << I);
                end else begin
                    rem_reg[k] <= rem_in;
                    q_reg[k]   <= q_in;
                end
            end
        end
    end

    assign quot = (den_reg[QUOT_W-1] == '0) ? '0 : q_reg[QUOT_W-1];

endmodule

`default_nettype wire

// ===== hdl/pinhole_ray_direction_gen_core.sv =====
// Pinhole camera ray direction generator, top level.
// Depends on prdg_pkg, prdg_sqrt_pipe, prdg_div_pipe and the assertion header.
//
// Usage: a pixel transaction (s_pixel_x, s_pixel_y) enters on the s_ channel
// and the unit world direction (m_dir_x, m_dir_y, m_dir_z, signed Q1.15)
// leaves on the m_ channel, one result for each pixel, in order.
// Camera registers are written through cfg_wr_en, cfg_index and cfg_wr_data
// while no transaction is in flight; the user must keep to this, as the block
// itself does not enforce it. Writes take effect at once. From acceptance to
// m_valid a pixel passes nine front stages for the projection, rotation and
// scaling, 31 stages of the square root (one root bit each) and 16 stages of
// the three dividers (one quotient bit each), then the output register.
// Throughput is one transaction per cycle while the output is not stalled.
// While a result waits at the output and m_ready is low, the whole pipeline
// holds and s_ready is low, so nothing is lost or repeated.
// Reset clears all valid bits and loads the default camera: unit tangents,
// identity rotation. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "pinhole_ray_direction_gen_core_assert.svh"

module pinhole_ray_direction_gen_core
    import prdg_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [COORD_W-1:0]     s_pixel_x,
    input  wire logic [COORD_W-1:0]     s_pixel_y,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [OUT_W-1:0]     m_dir_x,
    output logic signed [OUT_W-1:0]     m_dir_y,
    output logic signed [OUT_W-1:0]     m_dir_z
);

    logic [SCALE_W-1:0] scale_x_reg, scale_y_reg, tan_x_reg, tan_y_reg;
    logic [ROW_W-1:0]   rot_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_x_reg <= RST_SCALE_X;
            scale_y_reg <= RST_SCALE_Y;
            tan_x_reg   <= RST_TAN;
            tan_y_reg   <= RST_TAN;
            rot_reg[0]  <= RST_ROW0;
            rot_reg[1]  <= RST_ROW1;
            rot_reg[2]  <= RST_ROW2;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCALE_X:  scale_x_reg <= cfg_wr_data[SCALE_W-1:0];
                REG_SCALE_Y:  scale_y_reg <= cfg_wr_data[SCALE_W-1:0];
                REG_TAN_X:    tan_x_reg   <= cfg_wr_data[SCALE_W-1:0];
                REG_TAN_Y:    tan_y_reg   <= cfg_wr_data[SCALE_W-1:0];
                REG_ROT_ROW0: rot_reg[0]  <= cfg_wr_data[ROW_W-1:0];
                REG_ROT_ROW1: rot_reg[1]  <= cfg_wr_data[ROW_W-1:0];
                REG_ROT_ROW2: rot_reg[2]  <= cfg_wr_data[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [PIPE_LAT-1:0] v_reg;
    logic                pipe_adv;

    assign pipe_adv = !v_reg[PIPE_LAT-1] || m_ready;
    assign s_ready  = pipe_adv;
    assign m_valid  = v_reg[PIPE_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (pipe_adv) begin
            v_reg <= {v_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    // Projection of the pixel centre.
    logic [COORD_W-1:0] px_c, py_c;
    logic [PROD_W-1:0]  prodx_next, prody_next, prodx_reg, prody_reg;

    assign px_c = (s_pixel_x > COORD_MAX) ? COORD_MAX : s_pixel_x;
    assign py_c = (s_pixel_y > COORD_MAX) ? COORD_MAX : s_pixel_y;
    assign prodx_next = PROD_W'({px_c, 1'b1}) * PROD_W'(scale_x_reg);
    assign prody_next = PROD_W'({py_c, 1'b1}) * PROD_W'(scale_y_reg);

    logic signed [CAM_W-1:0] camx_next, camy_next, camx_reg, camy_reg;

    assign camx_next = $signed({2'b00, prodx_reg}) - $signed({6'd0, tan_x_reg, 9'd0});
    assign camy_next = $signed({6'd0, tan_y_reg, 9'd0}) - $signed({2'b00, prody_reg});

    // Rotation.
    logic signed [TERM_W-1:0] tx_next [0:2];
    logic signed [TERM_W-1:0] ty_next [0:2];
    logic signed [TERM_W-1:0] tx_reg  [0:2];
    logic signed [TERM_W-1:0] ty_reg  [0:2];
    logic signed [DIR_W-1:0]  d_next  [0:2];
    logic signed [DIR_W-1:0]  d_reg   [0:2];
    logic [DIR_W-1:0]         mag_next [0:2];
    logic [DIR_W-1:0]         mag_e_reg [0:2];
    logic [DIR_W-1:0]         mag_f_reg [0:2];
    logic [NORM_W-1:0]        a_next   [0:2];
    logic [NORM_W-1:0]        a_g_reg  [0:2];
    logic [NORM_W-1:0]        a_h_reg  [0:2];
    logic [NORM_W-1:0]        a_i_reg  [0:2];
    logic [SQ_W-1:0]          sq_reg   [0:2];
    logic [2:0]               neg_line [0:NEG_LAT-1];

    for (genvar r = 0; r < 3; r++) begin : g_row
        logic signed [ENT_W-1:0] e0, e1, e2;
        assign e0 = $signed(rot_reg[r][ENT_W-1:0]);
        assign e1 = $signed(rot_reg[r][2*ENT_W-1:ENT_W]);
        assign e2 = $signed(rot_reg[r][3*ENT_W-1:2*ENT_W]);
        assign tx_next[r] = TERM_W'(e0) * TERM_W'(camx_reg);
        assign ty_next[r] = TERM_W'(e1) * TERM_W'(camy_reg);
        assign d_next[r]  = DIR_W'(tx_reg[r]) + DIR_W'(ty_reg[r]) - (DIR_W'(e2) <<< 25);
        assign mag_next[r] = d_reg[r][DIR_W-1] ? DIR_W'(-d_reg[r]) : DIR_W'(d_reg[r]);
    end

    // Range reduction to 30 bits.
    logic [DIR_W-1:0]   maxm_next, maxm_reg;
    logic [SHIFT_W-1:0] hi_pos, shift_amt;

    always_comb begin
        maxm_next = mag_e_reg[0];
        if (mag_e_reg[1] > maxm_next) begin
            maxm_next = mag_e_reg[1];
        end
        if (mag_e_reg[2] > maxm_next) begin
            maxm_next = mag_e_reg[2];
        end
    end

    always_comb begin
        hi_pos = '0;
        for (int b = 0; b < DIR_W; b++) begin
            if (maxm_reg[b]) begin
                hi_pos = SHIFT_W'(b);
            end
        end
        shift_amt = (hi_pos >= SHIFT_W'(NORM_W)) ? hi_pos - SHIFT_W'(NORM_W - 1) : '0;
        for (int r = 0; r < 3; r++) begin
            a_next[r] = NORM_W'(mag_f_reg[r] >> shift_amt);
        end
    end

    logic [LSQ_W-1:0] lensq_next, lensq_reg;

    assign lensq_next = LSQ_W'(sq_reg[0]) + LSQ_W'(sq_reg[1]) + LSQ_W'(sq_reg[2]);

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            prodx_reg <= prodx_next;
            prody_reg <= prody_next;
            camx_reg  <= camx_next;
            camy_reg  <= camy_next;
            for (int r = 0; r < 3; r++) begin
                tx_reg[r]    <= tx_next[r];
                ty_reg[r]    <= ty_next[r];
                d_reg[r]     <= d_next[r];
                mag_e_reg[r] <= mag_next[r];
                mag_f_reg[r] <= mag_e_reg[r];
                a_g_reg[r]   <= a_next[r];
                a_h_reg[r]   <= a_g_reg[r];
                a_i_reg[r]   <= a_h_reg[r];
                sq_reg[r]    <= SQ_W'(a_g_reg[r]) * SQ_W'(a_g_reg[r]);
            end
            maxm_reg    <= maxm_next;
            lensq_reg   <= lensq_next;
            neg_line[0] <= {d_reg[2][DIR_W-1], d_reg[1][DIR_W-1], d_reg[0][DIR_W-1]};
            for (int k = 1; k < NEG_LAT; k++) begin
                neg_line[k] <= neg_line[k-1];
            end
        end
    end

    // Length.
    logic [ROOT_W-1:0] root;
    logic [NORM_W-1:0] a_line [0:SQRT_LAT-1][0:2];

    prdg_sqrt_pipe u_sqrt (
        .aclk (aclk),
        .en   (pipe_adv),
        .rad  (lensq_reg),
        .root (root)
    );

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            a_line[0] <= a_i_reg;
            for (int k = 1; k < SQRT_LAT; k++) begin
                a_line[k] <= a_line[k-1];
            end
        end
    end

    // Normalisation.
    logic [QUOT_W-1:0] quot [0:2];
    logic [NUM_W-1:0]  num  [0:2];

    for (genvar r = 0; r < 3; r++) begin : g_div
        assign num[r] = {1'b0, a_line[SQRT_LAT-1][r], FRAC_W'(0)} + NUM_W'(root >> 1);

        prdg_div_pipe u_div (
            .aclk (aclk),
            .en   (pipe_adv),
            .num  (num[r]),
            .den  (root),
            .quot (quot[r])
        );
    end

    logic signed [OUT_W-1:0] dir_next [0:2];
    logic signed [OUT_W-1:0] dir_reg  [0:2];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (neg_line[NEG_LAT-1][r]) begin
                dir_next[r] = $signed(OUT_W'(17'h10000 -
                              {1'b0, (quot[r] > Q_ONE) ? Q_ONE : quot[r]}));
            end else begin
                dir_next[r] = $signed((quot[r] > Q_POS_MAX) ? Q_POS_MAX : quot[r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            dir_reg <= dir_next;
        end
    end

    assign m_dir_x = dir_reg[0];
    assign m_dir_y = dir_reg[1];
    assign m_dir_z = dir_reg[2];

    `PRDG_ASSERT_IMP(a_within_len_chk, v_reg[FRONT_LAT+SQRT_LAT-1],
        a_line[SQRT_LAT-1][0] <= root && a_line[SQRT_LAT-1][1] <= root &&
        a_line[SQRT_LAT-1][2] <= root,
        "component magnitude exceeds vector length")
    `PRDG_ASSERT_IMP(quot_range_chk, v_reg[PIPE_LAT-2],
        quot[0] <= Q_ONE && quot[1] <= Q_ONE && quot[2] <= Q_ONE,
        "normalised component above one")
    `PRDG_ASSERT_NXT(stall_freeze_chk, !pipe_adv, $stable(v_reg),
        "pipeline moved while stalled")

endmodule

`default_nettype wire
